>>> rtl/assert_macros.svh
// Assertion helpers shared by the sequencer and result buffer modules of the frame serializer.
// Expects a clock named clock and an active-high reset named reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ofbs_pkg.sv
// Shared types and constants for the OOK frame bit serializer.
// No dependencies; the modules and the bench refer to it by scoped names.
package ofbs_pkg;

   // Operation codes of an input word
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_SEND  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   // Byte sent repeatedly as preamble
   localparam logic [7:0] PREAMBLE_PATTERN = 8'hAA;

   // Register map, indexed by paddr[2]
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic        REG_SYNC_WORD = 1'b0;
   localparam logic        REG_PREAMBLE  = 1'b1;
   localparam logic [7:0]  SYNC_WORD_RESET = 8'd45;
   localparam logic [7:0]  PREAMBLE_RESET  = 8'd4;

   typedef struct packed {
      logic [1:0] operation;
      logic [4:0] byte_slot;
      logic [7:0] byte_value;
      logic [7:0] frame_length;
   } req_item_type;

   typedef struct packed {
      logic accepted;
      logic bit_valid;
      logic bit_value;
      logic pin_level;
      logic idle;
   } rsp_item_type;

   typedef struct packed {
      logic [7:0] sync_word;
      logic [7:0] preamble_bytes;
   } cfg_type;

endpackage

>>> rtl/ofbs_req_if.sv
// Input channel of the frame serializer: valid/ready handshake plus one input word.
// Field layout matches ofbs_pkg::req_item_type.
interface ofbs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] operation;
   logic [4:0] byte_slot;
   logic [7:0] byte_value;
   logic [7:0] frame_length;

   modport source (output valid, operation, byte_slot, byte_value, frame_length,
                   input ready);
   modport sink   (input valid, operation, byte_slot, byte_value, frame_length,
                   output ready);
endinterface

>>> rtl/ofbs_rsp_if.sv
// Result channel of the frame serializer: valid/ready handshake plus one result word.
// Field layout matches ofbs_pkg::rsp_item_type.
interface ofbs_rsp_if;
   logic valid;
   logic ready;
   logic accepted;
   logic bit_valid;
   logic bit_value;
   logic pin_level;
   logic idle;

   modport source (output valid, accepted, bit_valid, bit_value, pin_level, idle,
                   input ready);
   modport sink   (input valid, accepted, bit_valid, bit_value, pin_level, idle,
                   output ready);
endinterface

>>> rtl/ofbs_csr.sv
// APB-style register block: sync word and preamble byte count.
// Depends on ofbs_pkg for the register map and reset values.
module ofbs_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ofbs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready,
   output ofbs_pkg::cfg_type                cfg
);

   logic [7:0] sync_ff;
   logic [7:0] sync_in;
   logic [7:0] pre_ff;
   logic [7:0] pre_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   // Decode the write on the word address
   always_comb begin
      sync_in = sync_ff;
      pre_in  = pre_ff;
      if (wr_en) begin
         case (paddr[2])
            ofbs_pkg::REG_SYNC_WORD: sync_in = pwdata[7:0];
            ofbs_pkg::REG_PREAMBLE:  pre_in  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff <= ofbs_pkg::SYNC_WORD_RESET;
         pre_ff  <= ofbs_pkg::PREAMBLE_RESET;
      end else begin
         sync_ff <= sync_in;
         pre_ff  <= pre_in;
      end
   end

   // Read back the addressed register
   always_comb begin
      case (paddr[2])
         ofbs_pkg::REG_SYNC_WORD: prdata = {24'd0, sync_ff};
         ofbs_pkg::REG_PREAMBLE:  prdata = {24'd0, pre_ff};
         default:                 prdata = 32'd0;
      endcase
   end

   assign cfg.sync_word      = sync_ff;
   assign cfg.preamble_bytes = pre_ff;

endmodule

>>> rtl/ofbs_seq.sv
// Frame sequencer: payload buffer, frame phase state and per-word result logic.
// Depends on ofbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ofbs_seq #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ofbs_pkg::req_item_type item,
   input  ofbs_pkg::cfg_type      cfg,
   output ofbs_pkg::rsp_item_type res
);

   localparam int         AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [8:0] MAX_W = 9'(MAX_PAYLOAD);

   typedef enum logic [2:0] {
      PH_IDLE, PH_PRE, PH_SYNC, PH_LEN, PH_DATA, PH_CK1, PH_CK2, PH_DONE
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [2:0] bit_pos_ff, bit_pos_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] pre_done_ff, pre_done_in;
   logic [7:0] len_ff, len_in;
   logic [7:0] check_ff, check_in;
   logic       line_ff, line_in;

   logic [7:0]    store_mem [MAX_PAYLOAD];
   logic [7:0]    rd_ff;
   logic          store_we;
   logic [7:0]    slot_ext;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;

   logic       byte_end;
   logic [2:0] bit_pos_step;
   logic [7:0] pre_done_inc;
   logic [7:0] pos_inc;
   logic [7:0] data_byte;
   logic       bit_val;
   logic       bit_vld;
   logic       acc;

   assign byte_end     = (bit_pos_ff == 3'd0);
   assign bit_pos_step = byte_end ? 3'd7 : bit_pos_ff - 3'd1;
   assign pre_done_inc = pre_done_ff + 8'd1;
   assign pos_inc      = pos_ff + 8'd1;
   assign data_byte    = ({1'b0, pos_ff} < MAX_W) ? rd_ff : 8'd0;
   assign slot_ext     = {3'd0, item.byte_slot};
   assign wr_addr      = slot_ext[AW-1:0];
   assign rd_addr      = pos_in[AW-1:0];

   // Decode the word and advance the frame by one bit on a tick
   always_comb begin
      phase_in    = phase_ff;
      bit_pos_in  = bit_pos_ff;
      pos_in      = pos_ff;
      pre_done_in = pre_done_ff;
      len_in      = len_ff;
      check_in    = check_ff;
      line_in     = line_ff;
      store_we    = 1'b0;
      acc         = 1'b0;
      bit_vld     = 1'b0;
      bit_val     = 1'b0;
      if (push) begin
         case (item.operation)
            ofbs_pkg::OP_WRITE: begin
               if (phase_ff == PH_IDLE && {1'b0, slot_ext} < MAX_W) begin
                  store_we = 1'b1;
                  acc      = 1'b1;
               end
            end
            ofbs_pkg::OP_SEND: begin
               if (phase_ff == PH_IDLE && {1'b0, item.frame_length} <= MAX_W) begin
                  len_in      = item.frame_length;
                  check_in    = cfg.sync_word ^ item.frame_length;
                  phase_in    = PH_PRE;
                  pre_done_in = 8'd0;
                  pos_in      = 8'd0;
                  bit_pos_in  = 3'd7;
                  acc         = 1'b1;
               end
            end
            ofbs_pkg::OP_TICK: begin
               case (phase_ff)
                  PH_PRE: begin
                     bit_val    = ofbs_pkg::PREAMBLE_PATTERN[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        pre_done_in = pre_done_inc;
                        if (pre_done_inc >= cfg.preamble_bytes) begin
                           phase_in = PH_SYNC;
                        end
                     end
                  end
                  PH_SYNC: begin
                     bit_val    = cfg.sync_word[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        phase_in = PH_LEN;
                     end
                  end
                  PH_LEN: begin
                     bit_val    = len_ff[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        pos_in   = 8'd0;
                        phase_in = (len_ff == 8'd0) ? PH_CK1 : PH_DATA;
                     end
                  end
                  PH_DATA: begin
                     bit_val    = data_byte[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        check_in = check_ff ^ data_byte;
                        pos_in   = pos_inc;
                        if (pos_inc >= len_ff) begin
                           phase_in = PH_CK1;
                        end
                     end
                  end
                  PH_CK1: begin
                     bit_val    = check_ff[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        phase_in = PH_CK2;
                     end
                  end
                  PH_CK2: begin
                     bit_val    = check_ff[bit_pos_ff];
                     bit_vld    = 1'b1;
                     bit_pos_in = bit_pos_step;
                     if (byte_end) begin
                        phase_in = PH_DONE;
                     end
                  end
                  PH_DONE: phase_in = PH_IDLE;
                  default: phase_in = PH_IDLE;
               endcase
               // Drop the line once the last check bit is out
               if (bit_vld) begin
                  line_in = (phase_in == PH_DONE) ? 1'b0 : bit_val;
               end
            end
            default: ;
         endcase
      end
   end

   assign res.accepted  = acc;
   assign res.bit_valid = bit_vld;
   assign res.bit_value = bit_val;
   assign res.pin_level = line_in;
   assign res.idle      = (phase_in == PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         bit_pos_ff  <= 3'd0;
         pos_ff      <= 8'd0;
         pre_done_ff <= 8'd0;
         len_ff      <= 8'd0;
         check_ff    <= 8'd0;
         line_ff     <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         bit_pos_ff  <= bit_pos_in;
         pos_ff      <= pos_in;
         pre_done_ff <= pre_done_in;
         len_ff      <= len_in;
         check_ff    <= check_in;
         line_ff     <= line_in;
      end
   end

   // Payload buffer; read data tracks the byte at the current payload position
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[wr_addr] <= item.byte_value;
      end
      rd_ff <= store_mem[rd_addr];
   end

   `ASSERT_NEXT(a_send_starts_preamble, push && acc && item.operation == ofbs_pkg::OP_SEND, phase_ff == PH_PRE, "accepted send did not enter preamble")
   `ASSERT_AT(a_data_pos_in_range, phase_ff != PH_DATA || pos_ff < len_ff, "payload position past frame length")

endmodule

>>> rtl/ofbs_skid.sv
// Two-entry result buffer: output register plus skid stage for the result channel.
// Depends on ofbs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ofbs_skid (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ofbs_pkg::rsp_item_type push_data,
   output logic                   can_push,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ofbs_pkg::rsp_item_type out_data
);

   ofbs_pkg::rsp_item_type out_ff, out_in;
   ofbs_pkg::rsp_item_type skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic                   pop;

   assign pop      = out_valid_ff && out_ready;
   assign can_push = !skid_valid_ff;

   // Refill the output register from the skid stage first, then from the new word
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_in       = push_data;
            skid_valid_in = push;
         end else begin
            out_in        = push_data;
            out_valid_in  = push;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   `ASSERT_AT(a_skid_behind_out, !skid_valid_ff || out_valid_ff, "skid holds a word while output is empty")
   `ASSERT_NEXT(a_skid_kept, skid_valid_ff && !pop, skid_valid_ff && $stable(skid_ff), "stalled skid word lost")

endmodule

>>> rtl/ook_frame_bit_serializer.sv
// OOK frame bit serializer, top level: register block, frame sequencer, result buffer.
// Depends on ofbs_pkg, ofbs_req_if, ofbs_rsp_if, ofbs_csr, ofbs_seq and ofbs_skid.
//
// Usage: each word on req_ch is a payload buffer write, a frame send or one
// bit-time tick. Every accepted word yields exactly one result word on rsp_ch
// (accepted flag, bit valid/value, line level, idle). A send streams the
// preamble (0xAA bytes), sync word, length, payload and the XOR check byte
// twice, MSB first, one bit per tick; the tick after the last bit returns the
// block to idle. Registers sync_word (0x0) and preamble_bytes (0x4) sit on the
// APB-style port; the user must write them only while the block is idle, which
// the block does not enforce. Each result is registered before rsp_ch shows it.
// Throughput: one word per cycle while req_ch.ready is high; each word's work is
// a single registered pass through the sequencer, and the payload buffer read is
// registered ahead of use, so no word waits on another.
// Stall: the output register and a skid stage hold two results; req_ch.ready is
// low while both are full, and rises the cycle after rsp_ch takes a result.
// Reset: synchronous; the block comes up idle with the line low, both result
// slots empty and the registers at their defaults. The payload buffer is not
// cleared and must be written before a send reads it.
module ook_frame_bit_serializer #(
   parameter int MAX_PAYLOAD = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   ofbs_req_if.sink                        req_ch,
   ofbs_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ofbs_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   ofbs_pkg::cfg_type      cfg;
   ofbs_pkg::req_item_type item;
   ofbs_pkg::rsp_item_type res;
   ofbs_pkg::rsp_item_type out_data;
   logic                   can_push;
   logic                   push;

   // Gather the input word and accept when the buffer has room
   assign item.operation    = req_ch.operation;
   assign item.byte_slot    = req_ch.byte_slot;
   assign item.byte_value   = req_ch.byte_value;
   assign item.frame_length = req_ch.frame_length;
   assign req_ch.ready      = can_push;
   assign push              = req_ch.valid && can_push;

   ofbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ofbs_seq #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .item  (item),
      .cfg   (cfg),
      .res   (res)
   );

   ofbs_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (res),
      .can_push  (can_push),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (out_data)
   );

   // Drive the result fields
   assign rsp_ch.accepted  = out_data.accepted;
   assign rsp_ch.bit_valid = out_data.bit_valid;
   assign rsp_ch.bit_value = out_data.bit_value;
   assign rsp_ch.pin_level = out_data.pin_level;
   assign rsp_ch.idle      = out_data.idle;

endmodule

>>> tb/sv/ook_frame_bit_serializer_tb.sv
// Self-checking bench for the OOK frame bit serializer: random and directed words,
// an in-bench frame predictor, and random stalls on both channels.
// Depends on ofbs_pkg, ofbs_req_if, ofbs_rsp_if and ook_frame_bit_serializer.
`timescale 1ns / 100ps

module ook_frame_bit_serializer_tb;

   localparam int          PAYLOAD_SLOTS = 32;
   localparam logic [7:0]  PAYLOAD_LIMIT = 8'd32;
   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam logic [ofbs_pkg::CSR_ADDR_W-1:0] ADDR_SYNC =
      {ofbs_pkg::REG_SYNC_WORD, 2'b00};
   localparam logic [ofbs_pkg::CSR_ADDR_W-1:0] ADDR_PREAMBLE =
      {ofbs_pkg::REG_PREAMBLE, 2'b00};
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int MAX_REPORTS   = 40;
   localparam int PHASE_BUDGET  = 80;

   typedef enum logic [2:0] {
      PH_IDLE, PH_PREAMBLE, PH_SYNC, PH_LENGTH,
      PH_PAYLOAD, PH_CHECK, PH_CHECK_AGAIN, PH_DONE
   } frame_phase_type;

   typedef struct packed {
      ofbs_pkg::cfg_type                 cfg;
      frame_phase_type                   phase;
      logic [2:0]                        bit_pos;
      logic [7:0]                        payload_pos;
      logic [7:0]                        preambles_sent;
      logic [7:0]                        length;
      logic [7:0]                        check;
      logic                              line;
      logic [PAYLOAD_SLOTS-1:0][7:0]     store;
   } framer_state_type;

   logic                            clock;
   logic                            reset   = 1'b1;
   logic                            psel    = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite  = 1'b0;
   logic [ofbs_pkg::CSR_ADDR_W-1:0] paddr   = '0;
   logic [31:0]                     pwdata  = '0;
   logic [31:0]                     prdata;
   logic                            pready;

   ofbs_req_if req_ch ();
   ofbs_rsp_if rsp_ch ();

   ook_frame_bit_serializer #(.MAX_PAYLOAD(PAYLOAD_SLOTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Words waiting for the driver, and line results the block still owes
   ofbs_pkg::req_item_type pending_words[$];
   ofbs_pkg::rsp_item_type expected_results[$];
   framer_state_type model_state;
   framer_state_type plan_state;
   logic [PAYLOAD_SLOTS-1:0] slot_written = '0;
   int            planned_words  = 0;
   int            results_seen   = 0;
   int            mismatch_count = 0;
   int            quiet_cycles   = 0;
   int            send_idle_pct  = 0;
   int            recv_stall_pct = 0;
   string         result_field[5] = '{"idle", "pin_level", "bit_value", "bit_valid",
                                      "accepted"};

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic framer_state_type reset_framer();
      framer_state_type st;
      st = '0;
      st.cfg.sync_word      = ofbs_pkg::SYNC_WORD_RESET;
      st.cfg.preamble_bytes = ofbs_pkg::PREAMBLE_RESET;
      st.phase              = PH_IDLE;
      return st;
   endfunction

   // Apply one word to a framer state and return the line result it causes
   function automatic ofbs_pkg::rsp_item_type advance_frame(inout framer_state_type st,
                                                            input ofbs_pkg::req_item_type w);
      ofbs_pkg::rsp_item_type r;
      logic [7:0]   data_word;
      logic         byte_end;
      r         = '0;
      data_word = '0;
      byte_end  = (st.bit_pos == 3'd0);
      case (w.operation)
         ofbs_pkg::OP_WRITE: begin
            // the slot field cannot exceed the buffer, so only busy refuses
            if (st.phase == PH_IDLE) begin
               st.store[w.byte_slot] = w.byte_value;
               r.accepted = 1'b1;
            end
         end
         ofbs_pkg::OP_SEND: begin
            if (st.phase == PH_IDLE && w.frame_length <= PAYLOAD_LIMIT) begin
               st.length         = w.frame_length;
               st.check          = st.cfg.sync_word ^ w.frame_length;
               st.phase          = PH_PREAMBLE;
               st.preambles_sent = 8'd0;
               st.payload_pos    = 8'd0;
               st.bit_pos        = 3'd7;
               r.accepted        = 1'b1;
            end
         end
         ofbs_pkg::OP_TICK: begin
            case (st.phase)
               PH_PREAMBLE: begin
                  r.bit_value = ofbs_pkg::PREAMBLE_PATTERN[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) begin
                     st.preambles_sent = st.preambles_sent + 8'd1;
                     // a zero count still sends one preamble byte
                     if (st.preambles_sent >= st.cfg.preamble_bytes) st.phase = PH_SYNC;
                  end
               end
               PH_SYNC: begin
                  r.bit_value = st.cfg.sync_word[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) st.phase = PH_LENGTH;
               end
               PH_LENGTH: begin
                  r.bit_value = st.length[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) begin
                     st.payload_pos = 8'd0;
                     st.phase = (st.length == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                  end
               end
               PH_PAYLOAD: begin
                  data_word   = st.store[st.payload_pos[4:0]];
                  r.bit_value = data_word[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) begin
                     st.check       = st.check ^ data_word;
                     st.payload_pos = st.payload_pos + 8'd1;
                     if (st.payload_pos >= st.length) st.phase = PH_CHECK;
                  end
               end
               PH_CHECK: begin
                  r.bit_value = st.check[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) st.phase = PH_CHECK_AGAIN;
               end
               PH_CHECK_AGAIN: begin
                  r.bit_value = st.check[st.bit_pos];
                  r.bit_valid = 1'b1;
                  if (byte_end) st.phase = PH_DONE;
               end
               // done tick returns to idle; a tick while idle does nothing
               default: st.phase = PH_IDLE;
            endcase
            if (r.bit_valid) begin
               st.bit_pos = st.bit_pos - 3'd1;
               st.line    = (st.phase == PH_DONE) ? 1'b0 : r.bit_value;
            end
         end
         default: ;
      endcase
      r.pin_level = st.line;
      r.idle      = (st.phase == PH_IDLE);
      return r;
   endfunction

   task automatic flag_mismatch(input string what);
      if (mismatch_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // Queue one word and track where the frame will be once it is taken
   task automatic plan_word(input logic [1:0] op, input logic [4:0] slot,
                            input logic [7:0] value, input logic [7:0] len);
      ofbs_pkg::req_item_type w;
      ofbs_pkg::rsp_item_type r;
      w.operation    = op;
      w.byte_slot    = slot;
      w.byte_value   = value;
      w.frame_length = len;
      r = advance_frame(plan_state, w);
      if (op == ofbs_pkg::OP_WRITE && r.accepted) slot_written[slot] = 1'b1;
      pending_words.push_back(w);
      planned_words++;
   endtask

   task automatic plan_tick();
      plan_word(ofbs_pkg::OP_TICK, 5'($urandom), 8'($urandom), 8'($urandom));
   endtask

   // Tick until the frame ends, with stray writes, sends and unused codes mixed in
   task automatic plan_to_idle();
      while (plan_state.phase != PH_IDLE) begin
         if ($urandom_range(0, 99) < 8)
            plan_word(2'($urandom), 5'($urandom), 8'($urandom), 8'($urandom));
         else
            plan_tick();
      end
   endtask

   // Load the buffer, start a frame and clock it out; a negative length picks one
   task automatic plan_frame(input int forced_len);
      int len;
      int pick;
      if (forced_len >= 0) begin
         len = forced_len;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 10)      len = $urandom_range(33, 255);
         else if (pick < 20) len = PAYLOAD_SLOTS;
         else if (pick < 35) len = 0;
         else                len = $urandom_range(1, 6);
      end
      if ($urandom_range(0, 9) == 0) plan_tick();
      if (len <= PAYLOAD_SLOTS) begin
         for (int s = 0; s < len; s++) begin
            if (!slot_written[s] || $urandom_range(0, 99) < 40)
               plan_word(ofbs_pkg::OP_WRITE, 5'(s), 8'($urandom), 8'($urandom));
         end
      end
      repeat ($urandom_range(0, 2))
         plan_word(ofbs_pkg::OP_WRITE, 5'($urandom), 8'($urandom), 8'($urandom));
      plan_word(ofbs_pkg::OP_SEND, 5'($urandom), 8'($urandom), 8'(len));
      plan_to_idle();
   endtask

   task automatic drain();
      while (pending_words.size() != 0 || req_ch.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the last edge
   task automatic write_register(input logic [ofbs_pkg::CSR_ADDR_W-1:0] addr,
                                 input logic [7:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {24'd0, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == ADDR_SYNC) begin
         model_state.cfg.sync_word = value;
         plan_state.cfg.sync_word  = value;
      end else begin
         model_state.cfg.preamble_bytes = value;
         plan_state.cfg.preamble_bytes  = value;
      end
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input logic [7:0] sync,
                            input logic [7:0] preamble, input int budget, input int forced_len);
      int target;
      write_register(ADDR_SYNC, sync);
      write_register(ADDR_PREAMBLE, preamble);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      target = planned_words + budget;
      while (planned_words < target) plan_frame(forced_len);
      drain();
   endtask

   // Stimulus and phase sequencing
   initial begin
      req_ch.valid        = 1'b0;
      req_ch.operation    = ofbs_pkg::OP_TICK;
      req_ch.byte_slot    = '0;
      req_ch.byte_value   = '0;
      req_ch.frame_length = '0;
      rsp_ch.ready        = 1'b0;
      model_state = reset_framer();
      plan_state  = reset_framer();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct  = 15;
      recv_stall_pct = 71;
      // directed: idle tick, unused code, buffer extremes, refused and busy requests
      plan_word(ofbs_pkg::OP_TICK, 5'd31, 8'hFF, 8'hFF);
      plan_word(OP_UNUSED, 5'd31, 8'hFF, 8'hFF);
      plan_word(ofbs_pkg::OP_WRITE, 5'd0, 8'h00, 8'h00);
      plan_word(ofbs_pkg::OP_WRITE, 5'd31, 8'hFF, 8'hFF);
      plan_word(ofbs_pkg::OP_WRITE, 5'd1, 8'h5A, 8'h00);
      plan_word(ofbs_pkg::OP_WRITE, 5'd2, 8'hC3, 8'h00);
      plan_word(ofbs_pkg::OP_SEND, 5'd0, 8'h00, 8'd255);
      plan_word(ofbs_pkg::OP_SEND, 5'd0, 8'h00, 8'd33);
      plan_word(ofbs_pkg::OP_SEND, 5'd0, 8'h00, 8'd0);
      plan_word(ofbs_pkg::OP_WRITE, 5'd2, 8'h77, 8'h00);
      plan_word(ofbs_pkg::OP_SEND, 5'd0, 8'h00, 8'd1);
      plan_word(OP_UNUSED, 5'd0, 8'h00, 8'h00);
      plan_to_idle();
      plan_word(ofbs_pkg::OP_TICK, 5'd0, 8'h00, 8'h00);
      plan_word(ofbs_pkg::OP_SEND, 5'd31, 8'hFF, 8'd3);
      plan_to_idle();
      while (planned_words < PHASE_BUDGET) plan_frame(-1);
      drain();

      run_phase(15, 71, 8'h00, 8'd0, PHASE_BUDGET, -1);
      run_phase(71, 15, 8'hFF, 8'd1, PHASE_BUDGET, -1);
      run_phase(0, 0, 8'($urandom), 8'd2, PHASE_BUDGET, -1);
      run_phase(0, 0, 8'($urandom), 8'd3, PHASE_BUDGET, -1);

      if (mismatch_count == 0)
         $display("[ook_frame_bit_serializer] OK");
      else
         $display("[ook_frame_bit_serializer] ERROR");
      $finish;
   end

   // Driver: predict each taken word, then offer the next one or idle
   always @(posedge clock) begin
      ofbs_pkg::req_item_type w;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            w = {req_ch.operation, req_ch.byte_slot, req_ch.byte_value, req_ch.frame_length};
            expected_results.push_back(advance_frame(model_state, w));
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               w = pending_words.pop_front();
               req_ch.valid        <= 1'b1;
               req_ch.operation    <= w.operation;
               req_ch.byte_slot    <= w.byte_slot;
               req_ch.byte_value   <= w.byte_value;
               req_ch.frame_length <= w.frame_length;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each taken result with the oldest prediction, field by field
   always @(posedge clock) begin
      ofbs_pkg::rsp_item_type got;
      ofbs_pkg::rsp_item_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.accepted, rsp_ch.bit_valid, rsp_ch.bit_value, rsp_ch.pin_level,
                   rsp_ch.idle};
            if (expected_results.size() == 0) begin
               flag_mismatch($sformatf("result %0d arrived with none pending", results_seen));
            end else begin
               want = expected_results.pop_front();
               for (int i = 0; i < 5; i++) begin
                  if (got[i] !== want[i])
                     flag_mismatch($sformatf("result %0d %s got %b want %b", results_seen,
                                             result_field[i], got[i], want[i]));
               end
            end
            results_seen++;
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Watchdog: end the run when neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[ook_frame_bit_serializer] ERROR");
         $finish;
      end
   end

endmodule
